FILE: design/rpc_pkg.sv
package rpc_pkg;

    typedef logic signed [9:0] t_trig;
    typedef t_trig t_tab [256];

    localparam real PI = 3.14159265358979323846;

    localparam t_trig THIRTY_SIN [12] = '{
        10'sd0, 10'sd128, 10'sd221, 10'sd256, 10'sd221, 10'sd128,
        10'sd0, -10'sd128, -10'sd221, -10'sd256, -10'sd221, -10'sd128
    };

    // register indexes
    localparam logic [2:0] CFG_SCALE  = 3'd0;
    localparam logic [2:0] CFG_CAMERA = 3'd1;
    localparam logic [2:0] CFG_NEAR   = 3'd2;
    localparam logic [2:0] CFG_FOCAL  = 3'd3;
    localparam logic [2:0] CFG_CX     = 3'd4;
    localparam logic [2:0] CFG_CY     = 3'd5;

    localparam logic [7:0] RST_SCALE  = 8'd80;
    localparam logic [9:0] RST_CAMERA = 10'd300;
    localparam logic [9:0] RST_NEAR   = 10'd50;
    localparam logic [9:0] RST_FOCAL  = 10'd200;
    localparam logic [9:0] RST_CX     = 10'd160;
    localparam logic [9:0] RST_CY     = 10'd120;

    localparam int NUM_W   = 28;
    localparam int DEN_W   = 17;
    localparam int LATENCY = 38;

endpackage

FILE: design/rpc_div.sv
module rpc_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);

    localparam int AW = DEN_W + NUM_W;

    // acc holds {remainder, dividend bits not yet used / quotient bits}
    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                               input logic [DEN_W-1:0] den);
        logic [DEN_W:0] top;
        logic [DEN_W:0] t;
        top = acc[AW-1 -: DEN_W+1];
        t = top - {1'b0, den};
        if (!t[DEN_W]) begin
            div_step = {t[DEN_W-1:0], acc[NUM_W-2:0], 1'b1};
        end else begin
            div_step = {acc[AW-2:0], 1'b0};
        end
    endfunction

    logic [AW-1:0]    r_acc [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic             r_neg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_acc[0] <= div_step({{DEN_W{1'b0}}, i_num}, i_den);
                r_den[0] <= i_den;
                r_neg[0] <= i_neg;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_acc[k] <= div_step(r_acc[k-1], r_den[k-1]);
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_quo = r_acc[NUM_W-1][NUM_W-1:0];
    assign o_neg = r_neg[NUM_W-1];

endmodule

FILE: design/triangle_rotate_project_cull_core.sv
// triangle rotate, project and backface cull pipeline
//
// input: a triangle word (frame phase and three vertices of signed 8-bit
// model coordinates) is taken at each rising edge with start high and busy
// low. busy is always low: a new word may enter every cycle.
// output: o_done marks one cycle that carries the three screen points and
// the visible flag; the receiver takes it in that cycle and cannot stall.
// throughput one triangle per cycle. a word passes the scale and trig
// lookup stage, two rotation passes, the depth clamp, the focal multiply,
// the 28-stage one-bit-per-stage divider used for the perspective divide,
// the screen point, edge and cross-term stages, and the registered area test.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 scale, 1 camera distance, 2 near clamp, 3 focal length, 4 center x,
// 5 center y); other indexes are ignored. write only while idle.
// reset (synchronous, active low) restores register defaults and drops
// every item in flight; no result appears until a new word enters.
module triangle_rotate_project_cull_core #(
    parameter int ANGLE_STEPS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic [7:0]         i_frame_phase,
    input  logic signed [7:0]  i_v0_x,
    input  logic signed [7:0]  i_v0_y,
    input  logic signed [7:0]  i_v0_z,
    input  logic signed [7:0]  i_v1_x,
    input  logic signed [7:0]  i_v1_y,
    input  logic signed [7:0]  i_v1_z,
    input  logic signed [7:0]  i_v2_x,
    input  logic signed [7:0]  i_v2_y,
    input  logic signed [7:0]  i_v2_z,
    output logic               o_done,
    output logic signed [15:0] o_p0_x,
    output logic signed [15:0] o_p0_y,
    output logic signed [15:0] o_p1_x,
    output logic signed [15:0] o_p1_y,
    output logic signed [15:0] o_p2_x,
    output logic signed [15:0] o_p2_y,
    output logic               o_visible
);

    localparam int NW = rpc_pkg::NUM_W;
    localparam int DW = rpc_pkg::DEN_W;

    // tables indexed directly by phase: the angle wrap is folded in here
    function automatic rpc_pkg::t_tab build_tab(input logic want_cos, input logic dbl);
        rpc_pkg::t_tab tab;
        int idx;
        int k;
        real a;
        for (int p = 0; p < 256; p++) begin
            idx = (dbl ? 2 * p : p) % ANGLE_STEPS;
            if ((12 * idx) % ANGLE_STEPS == 0) begin
                k = (12 * idx) / ANGLE_STEPS + (want_cos ? 3 : 0);
                tab[p] = rpc_pkg::THIRTY_SIN[k % 12];
            end else begin
                a = 2.0 * rpc_pkg::PI * idx / ANGLE_STEPS;
                a = 256.0 * (want_cos ? $cos(a) : $sin(a));
                tab[p] = rpc_pkg::t_trig'($rtoi(a));
            end
        end
        return tab;
    endfunction

    localparam rpc_pkg::t_tab TAB_SX = build_tab(1'b0, 1'b0);
    localparam rpc_pkg::t_tab TAB_CX = build_tab(1'b1, 1'b0);
    localparam rpc_pkg::t_tab TAB_SY = build_tab(1'b0, 1'b1);
    localparam rpc_pkg::t_tab TAB_CY = build_tab(1'b1, 1'b1);

    // configuration registers
    logic [7:0] r_scale;
    logic [9:0] r_camera, r_near, r_focal, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= rpc_pkg::RST_SCALE;
            r_camera <= rpc_pkg::RST_CAMERA;
            r_near   <= rpc_pkg::RST_NEAR;
            r_focal  <= rpc_pkg::RST_FOCAL;
            r_cx     <= rpc_pkg::RST_CX;
            r_cy     <= rpc_pkg::RST_CY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpc_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[7:0];
                rpc_pkg::CFG_CAMERA: r_camera <= i_cfg_data;
                rpc_pkg::CFG_NEAR:   r_near   <= i_cfg_data;
                rpc_pkg::CFG_FOCAL:  r_focal  <= i_cfg_data;
                rpc_pkg::CFG_CX:     r_cx     <= i_cfg_data;
                rpc_pkg::CFG_CY:     r_cy     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    logic signed [7:0] vx [3], vy [3], vz [3];
    assign vx = '{i_v0_x, i_v1_x, i_v2_x};
    assign vy = '{i_v0_y, i_v1_y, i_v2_y};
    assign vz = '{i_v0_z, i_v1_z, i_v2_z};

    // valid bits
    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic [NW-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0; r_v10 <= 1'b0;
            r_dv <= '0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_dv <= {r_dv[NW-2:0], r_v6};
            r_v7 <= r_dv[NW-1];
            r_v8 <= r_v7;
            r_v9 <= r_v8;
            r_v10 <= r_v9;
        end
    end

    // stage 1: scale and trig lookup
    logic signed [16:0] r1_x [3], r1_y [3], r1_z [3];
    logic signed [9:0]  r1_sy, r1_cy, r1_sx, r1_cx;
    // stage 2: first rotation products
    logic signed [26:0] r2_a [3], r2_b [3], r2_c [3], r2_d [3];
    logic signed [16:0] r2_y [3];
    logic signed [9:0]  r2_sx, r2_cx;
    // stage 3: rx, rz
    logic signed [17:0] r3_rx [3], r3_rz [3];
    logic signed [16:0] r3_y [3];
    logic signed [9:0]  r3_sx, r3_cx;
    // stage 4: second rotation products
    logic signed [26:0] r4_e [3], r4_g [3];
    logic signed [27:0] r4_f [3], r4_h [3];
    logic signed [17:0] r4_rx [3];
    // stage 5: ry and clamped depth
    logic signed [17:0] r5_rx [3], r5_ry [3];
    logic [DW-1:0]      r5_d [3];
    // stage 6: focal products as magnitude and sign
    logic [NW-1:0]      r6_num [6];
    logic               r6_neg [6];
    logic [DW-1:0]      r6_d [3];

    logic [9:0] nc;
    assign nc = (r_near == 10'd0) ? 10'd1 : r_near;

    always_ff @(posedge i_clk) begin
        logic signed [27:0] s28;
        logic signed [28:0] s29;
        logic signed [18:0] d19;
        logic signed [28:0] p29;
        r1_sy <= TAB_SY[i_frame_phase];
        r1_cy <= TAB_CY[i_frame_phase];
        r1_sx <= TAB_SX[i_frame_phase];
        r1_cx <= TAB_CX[i_frame_phase];
        r2_sx <= r1_sx; r2_cx <= r1_cx;
        r3_sx <= r2_sx; r3_cx <= r2_cx;
        for (int v = 0; v < 3; v++) begin
            r1_x[v] <= vx[v] * $signed({1'b0, r_scale});
            r1_y[v] <= vy[v] * $signed({1'b0, r_scale});
            r1_z[v] <= vz[v] * $signed({1'b0, r_scale});

            r2_a[v] <= r1_x[v] * r1_cy;
            r2_b[v] <= r1_z[v] * r1_sy;
            r2_c[v] <= r1_x[v] * r1_sy;
            r2_d[v] <= r1_z[v] * r1_cy;
            r2_y[v] <= r1_y[v];

            s28 = 28'(r2_a[v]) - 28'(r2_b[v]);
            r3_rx[v] <= s28[25:8];
            s28 = 28'(r2_c[v]) + 28'(r2_d[v]);
            r3_rz[v] <= s28[25:8];
            r3_y[v] <= r2_y[v];

            r4_e[v] <= r3_y[v] * r3_cx;
            r4_f[v] <= r3_rz[v] * r3_sx;
            r4_g[v] <= r3_y[v] * r3_sx;
            r4_h[v] <= r3_rz[v] * r3_cx;
            r4_rx[v] <= r3_rx[v];

            s29 = 29'(r4_e[v]) - 29'(r4_f[v]);
            r5_ry[v] <= s29[25:8];
            s29 = 29'(r4_g[v]) + 29'(r4_h[v]);
            d19 = $signed({9'd0, r_camera}) + 19'($signed(s29[25:8]));
            if (d19 < $signed({9'd0, nc})) begin
                r5_d[v] <= DW'(nc);
            end else begin
                r5_d[v] <= d19[DW-1:0];
            end
            r5_rx[v] <= r4_rx[v];

            p29 = r5_rx[v] * $signed({1'b0, r_focal});
            r6_neg[2*v] <= p29[28];
            r6_num[2*v] <= p29[28] ? NW'(-p29) : NW'(p29);
            p29 = r5_ry[v] * $signed({1'b0, r_focal});
            r6_neg[2*v+1] <= p29[28];
            r6_num[2*v+1] <= p29[28] ? NW'(-p29) : NW'(p29);
            r6_d[v] <= r5_d[v];
        end
    end

    logic [NW-1:0] quo [6];
    logic          qneg [6];

    for (genvar j = 0; j < 6; j++) begin : g_div
        rpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
            .i_clk (i_clk),
            .i_num (r6_num[j]),
            .i_den (r6_d[j/2]),
            .i_neg (r6_neg[j]),
            .o_quo (quo[j]),
            .o_neg (qneg[j])
        );
    end

    // stage 7: screen points, stage 8: edges, stage 9: cross terms
    logic signed [15:0] r7_p [6], r8_p [6], r9_p [6];
    logic signed [16:0] r8_dx1, r8_dy1, r8_dx2, r8_dy2;
    logic signed [33:0] r9_m1, r9_m2;

    always_ff @(posedge i_clk) begin
        logic [15:0] q16;
        logic [15:0] ctr;
        for (int j = 0; j < 6; j++) begin
            q16 = qneg[j] ? 16'(-quo[j][15:0]) : quo[j][15:0];
            ctr = (j % 2 == 0) ? {6'd0, r_cx} : {6'd0, r_cy};
            r7_p[j] <= $signed(ctr + q16);
        end
        r8_p <= r7_p;
        r8_dx1 <= 17'(r7_p[2]) - 17'(r7_p[0]);
        r8_dy1 <= 17'(r7_p[3]) - 17'(r7_p[1]);
        r8_dx2 <= 17'(r7_p[4]) - 17'(r7_p[0]);
        r8_dy2 <= 17'(r7_p[5]) - 17'(r7_p[1]);
        r9_p <= r8_p;
        r9_m1 <= r8_dx1 * r8_dy2;
        r9_m2 <= r8_dx2 * r8_dy1;
    end

    logic signed [34:0] area;
    assign area = 35'(r9_m1) - 35'(r9_m2);

    always_ff @(posedge i_clk) begin
        o_p0_x <= r9_p[0];
        o_p0_y <= r9_p[1];
        o_p1_x <= r9_p[2];
        o_p1_y <= r9_p[3];
        o_p2_x <= r9_p[4];
        o_p2_y <= r9_p[5];
        o_visible <= (area > 35'sd0);
    end

    assign o_done = r_v10;

endmodule

FILE: design/rpc_checker.sv
module rpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic               o_visible,
    input logic signed [15:0] o_p0_x,
    input logic signed [15:0] o_p0_y,
    input logic signed [15:0] o_p1_x,
    input logic signed [15:0] o_p1_y
);

    localparam int LAT = rpc_pkg::LATENCY;

    // every accepted word comes out after the fixed latency
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted word did not complete on time");

    // no result without a word accepted at the fixed latency before
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without matching accepted word");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

    // a triangle whose points p0 and p1 coincide has zero area
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_p0_x == o_p1_x && o_p0_y == o_p1_y) |-> !o_visible)
        else $error("degenerate triangle flagged visible");

endmodule

bind triangle_rotate_project_cull_core rpc_checker u_rpc_checker (.*);

FILE: verif/tb_triangle_rotate_project_cull_core.sv
module tb_triangle_rotate_project_cull_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE6 = 3'd6;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;
    localparam real TWO_PI = 6.283185307179586;

    typedef struct packed {
        logic [7:0]      phase;
        logic [8:0][7:0] crd;  // v0 x,y,z, v1 x,y,z, v2 x,y,z
    } t_tri_word;

    typedef struct packed {
        logic [2:0][15:0] px;
        logic [2:0][15:0] py;
        logic             vis;
    } t_screen;

    typedef struct packed {
        t_tri_word w;
        logic      typed;
        t_screen   val;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [9:0] i_cfg_data = '0;
    logic [7:0] i_frame_phase = '0;
    logic signed [7:0] i_v0_x = '0, i_v0_y = '0, i_v0_z = '0;
    logic signed [7:0] i_v1_x = '0, i_v1_y = '0, i_v1_z = '0;
    logic signed [7:0] i_v2_x = '0, i_v2_y = '0, i_v2_z = '0;
    logic o_done, o_visible;
    logic signed [15:0] o_p0_x, o_p0_y, o_p1_x, o_p1_y, o_p2_x, o_p2_y;

    triangle_rotate_project_cull_core dut (.*);

    always #5 i_clk = ~i_clk;

    int sin_tab [256];
    int cos_tab [256];
    longint scale_r, camera_r, near_r, focal_r, cx_r, cy_r;
    t_screen expected_screens [$];
    t_dir_row dir_rows [$];
    int mismatches = 0;
    bit gaps_on = 1'b1;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void build_trig();
        for (int i = 0; i < 256; i++) begin
            if (i % 64 == 0) begin
                sin_tab[i] = (i == 64) ? 256 : (i == 192) ? -256 : 0;
                cos_tab[i] = (i == 0) ? 256 : (i == 128) ? -256 : 0;
            end else begin
                sin_tab[i] = $rtoi(256.0 * $sin(TWO_PI * i / 256.0));
                cos_tab[i] = $rtoi(256.0 * $cos(TWO_PI * i / 256.0));
            end
        end
    endfunction

    function automatic t_screen predict_screen(t_tri_word w);
        t_screen r;
        longint sy, cy, sx, cx, nc, x, y, z, rx, ry, rz, d, dx1, dy1, dx2, dy2;
        longint px [3];
        longint py [3];
        sy = sin_tab[(2 * w.phase) % 256];
        cy = cos_tab[(2 * w.phase) % 256];
        sx = sin_tab[w.phase];
        cx = cos_tab[w.phase];
        nc = (near_r == 0) ? 1 : near_r;
        for (int v = 0; v < 3; v++) begin
            x = longint'($signed(w.crd[3 * v])) * scale_r;
            y = longint'($signed(w.crd[3 * v + 1])) * scale_r;
            z = longint'($signed(w.crd[3 * v + 2])) * scale_r;
            rx = (x * cy - z * sy) >>> 8;
            rz = (x * sy + z * cy) >>> 8;
            ry = (y * cx - rz * sx) >>> 8;
            rz = (y * sx + rz * cx) >>> 8;
            d = camera_r + rz;
            if (d < nc) d = nc;
            r.px[v] = 16'(cx_r + (rx * focal_r) / d);
            r.py[v] = 16'(cy_r + (ry * focal_r) / d);
            px[v] = longint'($signed(r.px[v]));
            py[v] = longint'($signed(r.py[v]));
        end
        dx1 = px[1] - px[0];
        dy1 = py[1] - py[0];
        dx2 = px[2] - px[0];
        dy2 = py[2] - py[0];
        r.vis = (dx1 * dy2 - dx2 * dy1 > 0);
        return r;
    endfunction

    // write enable stays high; the caller drops it after the last write
    task automatic cfg_write(logic [2:0] idx, logic [9:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rpc_pkg::CFG_SCALE:  scale_r = data[7:0];
            rpc_pkg::CFG_CAMERA: camera_r = data;
            rpc_pkg::CFG_NEAR:   near_r = data;
            rpc_pkg::CFG_FOCAL:  focal_r = data;
            rpc_pkg::CFG_CX:     cx_r = data;
            rpc_pkg::CFG_CY:     cy_r = data;
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [9:0] sc, logic [9:0] cam, logic [9:0] nr,
                           logic [9:0] fo, logic [9:0] cx, logic [9:0] cy);
        cfg_write(rpc_pkg::CFG_SCALE, sc);
        cfg_write(rpc_pkg::CFG_CAMERA, cam);
        cfg_write(rpc_pkg::CFG_NEAR, nr);
        cfg_write(rpc_pkg::CFG_FOCAL, fo);
        cfg_write(rpc_pkg::CFG_CX, cx);
        cfg_write(rpc_pkg::CFG_CY, cy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_screens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send(t_tri_word w, logic typed, t_screen val);
        int gap;
        start <= 1'b1;
        i_frame_phase <= w.phase;
        {i_v2_z, i_v2_y, i_v2_x, i_v1_z, i_v1_y, i_v1_x, i_v0_z, i_v0_y, i_v0_x} <= w.crd;
        do @(posedge i_clk); while (busy);
        expected_screens.push_back(typed ? val : predict_screen(w));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_tri_word random_word();
        t_tri_word w;
        w.phase = ($urandom_range(0, 9) == 0) ? 8'(64 * $urandom_range(0, 3)) : 8'($urandom);
        for (int k = 0; k < 9; k++) w.crd[k] = pick_coord();
        // sometimes repeat a vertex so the triangle collapses
        if ($urandom_range(0, 15) == 0) w.crd[8:6] = w.crd[2:0];
        return w;
    endfunction

    function automatic t_tri_word mk(logic [7:0] ph, int a0, int a1, int a2,
                                     int b0, int b1, int b2, int c0, int c1, int c2);
        t_tri_word w;
        w.phase = ph;
        w.crd = {8'(c2), 8'(c1), 8'(c0), 8'(b2), 8'(b1), 8'(b0), 8'(a2), 8'(a1), 8'(a0)};
        return w;
    endfunction

    // result side: a word is taken at the edge that ends its cycle
    always @(posedge i_clk) begin
        t_screen want;
        if (i_rst_n && o_done) begin
            if (expected_screens.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = expected_screens.pop_front();
                if (o_p0_x !== want.px[0]) report("p0_x", o_p0_x, $signed(want.px[0]));
                if (o_p0_y !== want.py[0]) report("p0_y", o_p0_y, $signed(want.py[0]));
                if (o_p1_x !== want.px[1]) report("p1_x", o_p1_x, $signed(want.px[1]));
                if (o_p1_y !== want.py[1]) report("p1_y", o_p1_y, $signed(want.py[1]));
                if (o_p2_x !== want.px[2]) report("p2_x", o_p2_x, $signed(want.px[2]));
                if (o_p2_y !== want.py[2]) report("p2_y", o_p2_y, $signed(want.py[2]));
                if (o_visible !== want.vis) report("visible", o_visible, want.vis);
            end
        end
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_screen centre, none;
        build_trig();
        scale_r = rpc_pkg::RST_SCALE; camera_r = rpc_pkg::RST_CAMERA;
        near_r = rpc_pkg::RST_NEAR; focal_r = rpc_pkg::RST_FOCAL;
        cx_r = rpc_pkg::RST_CX; cy_r = rpc_pkg::RST_CY;
        centre.px = {3{16'd160}};
        centre.py = {3{16'd120}};
        centre.vis = 1'b0;
        none = '0;

        dir_rows.push_back('{mk(8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, centre});
        dir_rows.push_back('{mk(8'd255, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, centre});
        dir_rows.push_back('{mk(8'd0, -128, -128, -128, 127, 127, 127, -128, 127, -128),
                             1'b0, none});
        dir_rows.push_back('{mk(8'd64, 127, 127, 127, 127, 127, 127, 127, 127, 127),
                             1'b0, none});
        dir_rows.push_back('{mk(8'd128, -128, 0, 0, 127, 0, 0, 0, 127, 0), 1'b0, none});
        dir_rows.push_back('{mk(8'd192, -128, 0, 0, 0, 127, 0, 127, 0, 0), 1'b0, none});
        dir_rows.push_back('{mk(8'd0, -20, -20, 0, 20, -20, 0, 0, 20, 0), 1'b0, none});
        dir_rows.push_back('{mk(8'd0, -20, -20, 0, 0, 20, 0, 20, -20, 0), 1'b0, none});
        dir_rows.push_back('{mk(8'd32, 10, 10, 10, 20, 20, 20, 30, 30, 30), 1'b0, none});
        dir_rows.push_back('{mk(8'd85, 0, 0, -128, 0, 0, 127, -128, 127, 0), 1'b0, none});
        dir_rows.push_back('{mk(8'd170, 127, -128, 127, -128, 127, -128, 1, -1, 1),
                             1'b0, none});
        dir_rows.push_back('{mk(8'd1, 0, 0, -128, 5, 5, -128, -5, 5, -128), 1'b0, none});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].val);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                // largest values everywhere, scale data with high bits set
                0: cfg_all(10'h3ff, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
                // divisor driven to its floor: near clamp of zero acts as one
                1: cfg_all(10'd255, 10'd0, 10'd0, 10'd1023, 10'd512, 10'd512);
                2: cfg_all(10'd0, 10'd0, 10'd1, 10'd0, 10'd0, 10'd0);
                3: begin
                    cfg_all(10'd80, 10'd300, 10'd50, 10'd200, 10'd160, 10'd120);
                    cfg_write(CFG_SPARE6, 10'h3ff);
                    cfg_write(CFG_SPARE7, 10'h155);
                end
                default: cfg_all(10'($urandom), 10'($urandom), 10'($urandom),
                                 10'($urandom), 10'($urandom), 10'($urandom));
            endcase
            i_cfg_we <= 1'b0;
            gaps_on = (ph != 6);
            repeat (220) send(random_word(), 1'b0, none);
            wait_idle();
        end

        repeat (rpc_pkg::LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_screens.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
